FILE: hdl/ac_phase_angle_firing_control_assert.svh
// Assertion macros for the phase-angle firing controller.
`ifndef AC_PHASE_ANGLE_FIRING_CONTROL_ASSERT_SVH
`define AC_PHASE_ANGLE_FIRING_CONTROL_ASSERT_SVH
`ifndef SYNTHESIS
`define APFC_ASSERT_HOLD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define APFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define APFC_ASSERT_HOLD(lbl, clk, rst, prop, msg)
`define APFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/apfc_pkg.sv
// Types, constants and the firing window function of the phase-angle controller.
package apfc_pkg;

   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_EDGE    = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT = 2'd2;

   localparam logic [2:0] CSR_DUTY_ONE   = 3'd0;
   localparam logic [2:0] CSR_DUTY_TWO   = 3'd1;
   localparam logic [2:0] CSR_FIRING_BASE = 3'd2;
   localparam logic [2:0] CSR_PULSE_WIDTH = 3'd3;
   localparam logic [2:0] CSR_MIN_GAP     = 3'd4;

   localparam logic [6:0]  DUTY_FULL_ON  = 7'd90;
   localparam logic [6:0]  DUTY_FULL_OFF = 7'd10;
   localparam logic [13:0] DUTY_STEP_US  = 14'd100;

   localparam logic [15:0] FIRING_BASE_RESET = 16'd10700;
   localparam logic [15:0] PULSE_WIDTH_RESET = 16'd1000;
   localparam logic [15:0] MIN_GAP_RESET     = 16'd9900;

   typedef struct packed {
      logic        gate_one;
      logic        gate_two;
      logic        mains_present;
      logic        edge_accepted;
      logic [15:0] crossing_total;
   } rsp_type;

   // Gate level for one channel on a sampling tick; 0 fires the load.
   function automatic logic window_gate(input logic [6:0]  duty,
                                        input logic [15:0] base,
                                        input logic [15:0] width,
                                        input logic [31:0] elapsed);
      logic [13:0]        step;
      logic signed [33:0] start_s;
      logic signed [33:0] end_s;
      logic signed [33:0] elapsed_s;
      logic               result;
      step      = 14'(duty) * DUTY_STEP_US;
      start_s   = $signed({18'd0, base}) - $signed({20'd0, step});
      end_s     = start_s + $signed({18'd0, width});
      elapsed_s = $signed({2'd0, elapsed});
      if (duty > DUTY_FULL_ON) begin
         result = 1'b0;
      end else if (duty < DUTY_FULL_OFF) begin
         result = 1'b1;
      end else begin
         result = (elapsed_s >= start_s && elapsed_s <= end_s) ? 1'b0 : 1'b1;
      end
      return result;
   endfunction

endpackage

FILE: hdl/apfc_req_if.sv
// Event channel: valid/ready handshake with event kind and timestamp.
interface apfc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] time_us;

   modport source (output valid, output req_type, output time_us, input ready);
   modport sink   (input valid, input req_type, input time_us, output ready);
endinterface

FILE: hdl/apfc_rsp_if.sv
// Result channel: valid/ready handshake with gate levels and crossing status.
interface apfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        gate_one;
   logic        gate_two;
   logic        mains_present;
   logic        edge_accepted;
   logic [15:0] crossing_total;

   modport source (output valid, output gate_one, output gate_two, output mains_present,
                   output edge_accepted, output crossing_total, input ready);
   modport sink   (input valid, input gate_one, input gate_two, input mains_present,
                   input edge_accepted, input crossing_total, output ready);
endinterface

FILE: hdl/ac_phase_angle_firing_control.sv
// Two-channel phase-angle firing controller, top level.
//
//   channel   direction  contents
//   req_chan  in         event kind, microsecond timestamp
//   rsp_chan  out        gate levels, mains present, edge accepted, crossing count
//   csr_*     in         write enable, register index, write data
//
// Each event is processed combinationally and its result is written into a
// two-entry output buffer, so one event can be accepted every cycle while an entry is free.
// The event channel stalls only while both buffer entries hold untaken results.
// Synchronous reset clears the controller state and empties the buffer.
`include "ac_phase_angle_firing_control_assert.svh"

module ac_phase_angle_firing_control (
   input  logic              clock,
   input  logic              reset,
   apfc_req_if.sink          req_chan,
   apfc_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wr_data
);

   logic [6:0]  duty_one_ff;
   logic [6:0]  duty_two_ff;
   logic [15:0] firing_base_ff;
   logic [15:0] pulse_width_ff;
   logic [15:0] min_gap_ff;

   logic        ac_flag_ff;
   logic        ac_flag_in;
   logic [31:0] last_time_ff;
   logic [31:0] last_time_in;
   logic [15:0] crossing_cnt_ff;
   logic [15:0] crossing_cnt_in;
   logic        gate_one_ff;
   logic        gate_one_in;
   logic        gate_two_ff;
   logic        gate_two_in;
   logic        edge_acc;

   apfc_pkg::rsp_type buf_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;

   logic [31:0] elapsed;
   logic        edge_ok;
   logic        push;
   logic        pop;
   apfc_pkg::rsp_type rsp_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_one_ff    <= '0;
         duty_two_ff    <= '0;
         firing_base_ff <= apfc_pkg::FIRING_BASE_RESET;
         pulse_width_ff <= apfc_pkg::PULSE_WIDTH_RESET;
         min_gap_ff     <= apfc_pkg::MIN_GAP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            apfc_pkg::CSR_DUTY_ONE:    duty_one_ff    <= csr_wr_data[6:0];
            apfc_pkg::CSR_DUTY_TWO:    duty_two_ff    <= csr_wr_data[6:0];
            apfc_pkg::CSR_FIRING_BASE: firing_base_ff <= csr_wr_data;
            apfc_pkg::CSR_PULSE_WIDTH: pulse_width_ff <= csr_wr_data;
            apfc_pkg::CSR_MIN_GAP:     min_gap_ff     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign push     = req_chan.valid && req_chan.ready;
   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign elapsed  = req_chan.time_us - last_time_ff;
   assign edge_ok  = elapsed > {16'd0, min_gap_ff};

   always_comb begin
      ac_flag_in      = ac_flag_ff;
      last_time_in    = last_time_ff;
      crossing_cnt_in = crossing_cnt_ff;
      gate_one_in     = gate_one_ff;
      gate_two_in     = gate_two_ff;
      edge_acc        = 1'b0;
      case (req_chan.req_type)
         apfc_pkg::REQ_EDGE: begin
            ac_flag_in = 1'b1;
            if (edge_ok) begin
               last_time_in    = req_chan.time_us;
               crossing_cnt_in = crossing_cnt_ff + 16'd1;
               gate_one_in     = 1'b1;
               gate_two_in     = 1'b1;
               edge_acc        = 1'b1;
            end
         end
         apfc_pkg::REQ_TICK: begin
            if (ac_flag_ff) begin
               gate_one_in = apfc_pkg::window_gate(duty_one_ff, firing_base_ff,
                                                   pulse_width_ff, elapsed);
               gate_two_in = apfc_pkg::window_gate(duty_two_ff, firing_base_ff,
                                                   pulse_width_ff, elapsed);
            end
         end
         apfc_pkg::REQ_TIMEOUT: begin
            ac_flag_in  = 1'b0;
            gate_one_in = (duty_one_ff == 7'd0);
            gate_two_in = (duty_two_ff == 7'd0);
         end
         default: ;
      endcase
   end

   assign rsp_entry.gate_one       = gate_one_in;
   assign rsp_entry.gate_two       = gate_two_in;
   assign rsp_entry.mains_present  = ac_flag_in;
   assign rsp_entry.edge_accepted  = edge_acc;
   assign rsp_entry.crossing_total = crossing_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_flag_ff      <= 1'b0;
         last_time_ff    <= '0;
         crossing_cnt_ff <= '0;
         gate_one_ff     <= 1'b1;
         gate_two_ff     <= 1'b1;
      end else if (push) begin
         ac_flag_ff      <= ac_flag_in;
         last_time_ff    <= last_time_in;
         crossing_cnt_ff <= crossing_cnt_in;
         gate_one_ff     <= gate_one_in;
         gate_two_ff     <= gate_two_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= rsp_entry;
      end
   end

   assign req_chan.ready          = (count_ff != 2'd2);
   assign rsp_chan.valid          = (count_ff != 2'd0);
   assign rsp_chan.gate_one       = buf_ff[rd_ptr_ff].gate_one;
   assign rsp_chan.gate_two       = buf_ff[rd_ptr_ff].gate_two;
   assign rsp_chan.mains_present  = buf_ff[rd_ptr_ff].mains_present;
   assign rsp_chan.edge_accepted  = buf_ff[rd_ptr_ff].edge_accepted;
   assign rsp_chan.crossing_total = buf_ff[rd_ptr_ff].crossing_total;

   `APFC_ASSERT_HOLD(a_count_bound, clock, reset, count_ff != 2'd3, "Output buffer count overflow")
   `APFC_ASSERT_NEXT(a_edge_counts, clock, reset, push && edge_acc, crossing_cnt_ff == 16'($past(crossing_cnt_ff) + 16'd1), "Accepted crossing not counted")
   `APFC_ASSERT_NEXT(a_timeout_clears, clock, reset, push && req_chan.req_type == apfc_pkg::REQ_TIMEOUT, !ac_flag_ff, "Timeout left mains present")
   `APFC_ASSERT_HOLD(a_edge_has_mains, clock, reset, rsp_chan.valid && rsp_chan.edge_accepted |-> rsp_chan.mains_present, "Accepted crossing without mains present")

endmodule

FILE: dv/tb_ac_phase_angle_firing_control.sv
// Testbench for the phase-angle firing controller: directed and random event streams checked by a scoreboard.
`timescale 1ns / 100ps

module tb_ac_phase_angle_firing_control;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         PHASES      = 12;
   localparam int         PHASE_ITEMS = 128;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wr_data;

   apfc_req_if req_chan();
   apfc_rsp_if rsp_chan();

   ac_phase_angle_firing_control dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   class firing_scoreboard;
      logic [6:0]  duty_one;
      logic [6:0]  duty_two;
      logic [15:0] firing_base;
      logic [15:0] pulse_width;
      logic [15:0] min_gap;
      logic        mains;
      logic [31:0] last_edge;
      logic [15:0] crossings;
      logic        gate_one;
      logic        gate_two;
      apfc_pkg::rsp_type expected_q[$];
      int          mismatches;

      function new();
         duty_one    = '0;
         duty_two    = '0;
         firing_base = apfc_pkg::FIRING_BASE_RESET;
         pulse_width = apfc_pkg::PULSE_WIDTH_RESET;
         min_gap     = apfc_pkg::MIN_GAP_RESET;
         mains       = 1'b0;
         last_edge   = '0;
         crossings   = '0;
         gate_one    = 1'b1;
         gate_two    = 1'b1;
         mismatches  = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [15:0] value);
         case (index)
            apfc_pkg::CSR_DUTY_ONE:    duty_one    = value[6:0];
            apfc_pkg::CSR_DUTY_TWO:    duty_two    = value[6:0];
            apfc_pkg::CSR_FIRING_BASE: firing_base = value;
            apfc_pkg::CSR_PULSE_WIDTH: pulse_width = value;
            apfc_pkg::CSR_MIN_GAP:     min_gap     = value;
            default: ;
         endcase
      endfunction

      function logic channel_level(logic [6:0] duty, logic [31:0] elapsed);
         longint b, d, w, e, s, lo, hi;
         b = firing_base;
         d = duty;
         w = pulse_width;
         e = elapsed;
         s = apfc_pkg::DUTY_STEP_US;
         if (duty > apfc_pkg::DUTY_FULL_ON) return 1'b0;
         if (duty < apfc_pkg::DUTY_FULL_OFF) return 1'b1;
         lo = b - d * s;
         hi = lo + w;
         return (e >= lo && e <= hi) ? 1'b0 : 1'b1;
      endfunction

      function void note_event(logic [1:0] kind, logic [31:0] stamp);
         logic [31:0]       elapsed;
         logic              took;
         apfc_pkg::rsp_type want;
         elapsed = stamp - last_edge;
         took    = 1'b0;
         case (kind)
            apfc_pkg::REQ_EDGE: begin
               mains = 1'b1;
               if (elapsed > {16'd0, min_gap}) begin
                  last_edge = stamp;
                  crossings = crossings + 16'd1;
                  gate_one  = 1'b1;
                  gate_two  = 1'b1;
                  took      = 1'b1;
               end
            end
            apfc_pkg::REQ_TICK: begin
               if (mains) begin
                  gate_one = channel_level(duty_one, elapsed);
                  gate_two = channel_level(duty_two, elapsed);
               end
            end
            apfc_pkg::REQ_TIMEOUT: begin
               mains    = 1'b0;
               gate_one = (duty_one != 0) ? 1'b0 : 1'b1;
               gate_two = (duty_two != 0) ? 1'b0 : 1'b1;
            end
            default: ;
         endcase
         want.gate_one       = gate_one;
         want.gate_two       = gate_two;
         want.mains_present  = mains;
         want.edge_accepted  = took;
         want.crossing_total = crossings;
         expected_q.push_back(want);
      endfunction

      function void check_result(apfc_pkg::rsp_type got);
         apfc_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: g1=%0b g2=%0b ac=%0b acc=%0b n=%0d",
                        got.gate_one, got.gate_two, got.mains_present,
                        got.edge_accepted, got.crossing_total);
            return;
         end
         want = expected_q.pop_front();
         if (got.gate_one !== want.gate_one || got.gate_two !== want.gate_two ||
             got.mains_present !== want.mains_present ||
             got.edge_accepted !== want.edge_accepted ||
             got.crossing_total !== want.crossing_total) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected g1=%0b g2=%0b ac=%0b acc=%0b n=%0d, ",
                         "got g1=%0b g2=%0b ac=%0b acc=%0b n=%0d"},
                        want.gate_one, want.gate_two, want.mains_present,
                        want.edge_accepted, want.crossing_total,
                        got.gate_one, got.gate_two, got.mains_present,
                        got.edge_accepted, got.crossing_total);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   firing_scoreboard sb;
   bit steady;
   bit hold_request;
   int items_sent;
   int cycles;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: checks every transfer and throttles ready.
   initial begin
      apfc_pkg::rsp_type got;
      int      burst_left;
      int      hold_left;
      int      r;
      logic    burst_level;
      logic    next_ready;
      burst_left = 0;
      hold_left = 0;
      burst_level = 1'b1;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.gate_one       = rsp_chan.gate_one;
            got.gate_two       = rsp_chan.gate_two;
            got.mains_present  = rsp_chan.mains_present;
            got.edge_accepted  = rsp_chan.edge_accepted;
            got.crossing_total = rsp_chan.crossing_total;
            sb.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 250;
            next_ready = 1'b0;
         end else if (steady) begin
            next_ready = 1'b1;
         end else begin
            if (burst_left == 0) begin
               r = $urandom_range(0, 9);
               if (r < 5) begin
                  burst_level = 1'b1;
                  burst_left = $urandom_range(1, 8);
               end else if (r < 8) begin
                  burst_level = 1'b0;
                  burst_left = $urandom_range(1, 3);
               end else if (r == 8) begin
                  burst_level = 1'b1;
                  burst_left = $urandom_range(30, 80);
               end else begin
                  burst_level = 1'b0;
                  burst_left = $urandom_range(10, 30);
               end
            end
            burst_left--;
            next_ready = burst_level;
         end
         rsp_chan.ready <= next_ready;
      end
   end

   task automatic send_event(input logic [1:0] kind, input logic [31:0] stamp);
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.time_us  <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_event(kind, stamp);
      items_sent++;
   endtask

   task automatic offer(input logic [1:0] kind, input logic [31:0] stamp);
      int r;
      int gap;
      gap = 0;
      if (!steady) begin
         r = $urandom_range(0, 19);
         if (r >= 18) gap = $urandom_range(10, 40);
         else if (r >= 12) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_event(kind, stamp);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   task automatic apply_setting(input logic [6:0] d1, input logic [6:0] d2,
                                input logic [15:0] base, input logic [15:0] width,
                                input logic [15:0] gap);
      write_register(apfc_pkg::CSR_DUTY_ONE, {9'd0, d1});
      write_register(apfc_pkg::CSR_DUTY_TWO, {9'd0, d2});
      write_register(apfc_pkg::CSR_FIRING_BASE, base);
      write_register(apfc_pkg::CSR_PULSE_WIDTH, width);
      write_register(apfc_pkg::CSR_MIN_GAP, gap);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [6:0] pick_duty();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd9;
         2: return 7'd10;
         3: return 7'd90;
         4: return 7'd91;
         5: return 7'd100;
         6: return 7'($urandom_range(101, 127));
         default: return 7'($urandom_range(0, 100));
      endcase
   endfunction

   function automatic logic [15:0] pick_span(input int lo, input int hi);
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom());
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   // Tick time aimed mostly at the edges of a channel's firing window.
   function automatic logic [31:0] tick_stamp();
      longint lo, hi, el, s;
      int     off;
      logic [6:0] d;
      d   = $urandom_range(0, 1) ? sb.duty_one : sb.duty_two;
      s   = apfc_pkg::DUTY_STEP_US;
      lo  = sb.firing_base;
      lo  = lo - longint'(d) * s;
      hi  = lo + longint'(sb.pulse_width);
      off = $urandom_range(0, 2);
      case ($urandom_range(0, 5))
         0, 1: el = lo + off - 1;
         2, 3: el = hi + off - 1;
         4: el = $urandom_range(0, 32'(sb.firing_base) + 32'(sb.pulse_width) + 1000);
         default: el = $urandom();
      endcase
      return sb.last_edge + el[31:0];
   endfunction

   function automatic logic [31:0] edge_stamp();
      logic [31:0] gap32;
      gap32 = {16'd0, sb.min_gap};
      case ($urandom_range(0, 9))
         0: return sb.last_edge + gap32;
         1: return sb.last_edge + gap32 + 32'd1;
         2: return sb.last_edge + $urandom_range(0, gap32);
         default: return sb.last_edge + gap32 + $urandom_range(2, 400);
      endcase
   endfunction

   task automatic random_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 78) begin
         offer(apfc_pkg::REQ_EDGE, edge_stamp());
         repeat ($urandom_range(1, 6)) offer(apfc_pkg::REQ_TICK, tick_stamp());
         if ($urandom_range(0, 4) == 0)
            offer(apfc_pkg::REQ_EDGE,
                  sb.last_edge + $urandom_range(0, {16'd0, sb.min_gap}));
      end else if (r < 88) begin
         offer(apfc_pkg::REQ_TIMEOUT, $urandom());
         repeat ($urandom_range(1, 3)) offer(apfc_pkg::REQ_TICK, $urandom());
      end else if (r < 94) begin
         offer(REQ_UNUSED, $urandom());
      end else begin
         offer(apfc_pkg::REQ_EDGE, $urandom());
      end
   endtask

   initial begin
      int start_count;
      sb = new();
      steady = 1'b0;
      hold_request = 1'b0;
      items_sent = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.req_type = apfc_pkg::REQ_TICK;
      req_chan.time_us = '0;
      csr_wr_en = 1'b0;
      csr_index = apfc_pkg::CSR_DUTY_ONE;
      csr_wr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      apply_setting(7'd50, 7'd95, apfc_pkg::FIRING_BASE_RESET,
                    apfc_pkg::PULSE_WIDTH_RESET, apfc_pkg::MIN_GAP_RESET);
      offer(apfc_pkg::REQ_TICK, 32'd0);
      offer(REQ_UNUSED, 32'd5);
      offer(apfc_pkg::REQ_TIMEOUT, 32'd100);
      offer(apfc_pkg::REQ_EDGE, 32'd9900);
      offer(apfc_pkg::REQ_EDGE, 32'd9901);
      offer(apfc_pkg::REQ_TICK, 32'd9901 + 32'd5699);
      offer(apfc_pkg::REQ_TICK, 32'd9901 + 32'd5700);
      offer(apfc_pkg::REQ_TICK, 32'd9901 + 32'd6700);
      offer(apfc_pkg::REQ_TICK, 32'd9901 + 32'd6701);
      offer(apfc_pkg::REQ_EDGE, 32'd10001);
      offer(apfc_pkg::REQ_EDGE, 32'hFFFF_FF00);
      offer(apfc_pkg::REQ_EDGE, 32'h0000_2800);
      offer(apfc_pkg::REQ_TICK, 32'hFFFF_FFFF);
      offer(apfc_pkg::REQ_TIMEOUT, 32'hFFFF_FFFF);
      drain();
      apply_setting(7'd10, 7'd90, 16'd0, 16'hFFFF, 16'd0);
      offer(apfc_pkg::REQ_EDGE, 32'd1000);
      offer(apfc_pkg::REQ_EDGE, 32'd1000);
      offer(apfc_pkg::REQ_TICK, 32'd1000);
      offer(apfc_pkg::REQ_TICK, 32'd1000 + 32'd64535);
      offer(apfc_pkg::REQ_TICK, 32'd1000 + 32'd64536);
      drain();
      apply_setting(7'd9, 7'd91, 16'hFFFF, 16'd0, 16'hFFFF);
      offer(apfc_pkg::REQ_EDGE, 32'd1000 + 32'd65535);
      offer(apfc_pkg::REQ_EDGE, 32'd1000 + 32'd65536);
      offer(apfc_pkg::REQ_TICK, 32'd66536);
      drain();
      apply_setting(7'd100, 7'd127, apfc_pkg::FIRING_BASE_RESET,
                    apfc_pkg::PULSE_WIDTH_RESET, apfc_pkg::MIN_GAP_RESET);
      offer(apfc_pkg::REQ_TICK, 32'd70000);
      offer(apfc_pkg::REQ_TIMEOUT, 32'd70001);
      drain();
      apply_setting(7'd0, 7'd0, apfc_pkg::FIRING_BASE_RESET,
                    apfc_pkg::PULSE_WIDTH_RESET, apfc_pkg::MIN_GAP_RESET);
      offer(apfc_pkg::REQ_TIMEOUT, 32'd1);
      offer(apfc_pkg::REQ_EDGE, 32'd80000);
      offer(apfc_pkg::REQ_TICK, 32'd80001);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: apply_setting(7'd0, 7'd0, apfc_pkg::FIRING_BASE_RESET,
                             apfc_pkg::PULSE_WIDTH_RESET, apfc_pkg::MIN_GAP_RESET);
            1: apply_setting(7'd100, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: apply_setting(7'd0, 7'd10, 16'd0, 16'd0, 16'd0);
            default: apply_setting(pick_duty(), pick_duty(), pick_span(3000, 15000),
                                   pick_span(0, 2500), pick_span(5000, 12000));
         endcase
         steady = (phase % 4 == 3);
         if (phase == 5) begin
            hold_request = 1'b1;
            send_event(apfc_pkg::REQ_EDGE, $urandom());
            repeat (40) send_event(apfc_pkg::REQ_TICK, tick_stamp());
         end
         offer(apfc_pkg::REQ_EDGE, ($urandom_range(0, 3) == 0) ?
                         32'hFFFF_FFFF - $urandom_range(0, 30000) : $urandom());
         start_count = items_sent;
         while (items_sent - start_count < PHASE_ITEMS) random_step();
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
